/* design/cbnc_pkg.sv */
package cbnc_pkg;

  localparam int MAX_CLUSTERS_DEF = 64;
  localparam int FEATURE_DIM_DEF  = 32;
  localparam int MAX_COLUMNS_DEF  = 65536;

  localparam logic [39:0] SAT40      = 40'hFF_FFFF_FFFF;
  localparam logic [6:0]  UNASSIGNED = 7'd64;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_COLUMN = 2'd2;

  localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_MIN_CAP      = 2'd1;
  localparam logic [1:0] REG_MAX_CAP      = 2'd2;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic        wr;
    logic [5:0]  wr_sel;
    logic [5:0]  addr;
    logic [15:0] value;
    logic        rd;
    logic        sq;
    logic        acc;
    logic        clr_acc;
    logic        clr_load;
    logic        upd;
    logic [5:0]  win;
    logic [19:0] nnz;
    logic [39:0] min_cap;
    logic [39:0] max_cap;
    logic [6:0]  keff;
  } ctrl_t;

  // running selection handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [41:0] key;
    logic [5:0]  idx;
    logic [39:0] ml_load;
    logic [5:0]  ml_idx;
  } cand_t;

  function automatic logic [39:0] sat_add40(input logic [39:0] a, input logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? SAT40 : s[39:0];
  endfunction

endpackage

/* design/cbnc_cell.sv */
module cbnc_cell #(
  parameter int IDX         = 0,
  parameter int FEATURE_DIM = cbnc_pkg::FEATURE_DIM_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cbnc_pkg::ctrl_t ctrl,
  input  cbnc_pkg::cand_t cand_in,
  output cbnc_pkg::cand_t cand_out
);

  localparam int AW = $clog2(FEATURE_DIM);

  logic [15:0] cent_mem [FEATURE_DIM];
  logic [15:0] cent_q_r;
  logic [31:0] sq_r;
  logic [39:0] acc_r;
  logic [39:0] load_r;
  cbnc_pkg::cand_t cand_r;
  cbnc_pkg::cand_t cand_nxt;

  logic [15:0] diff;
  logic [40:0] need;
  logic        elig;
  logic        active;
  logic [41:0] key;

  always_ff @(posedge clk) begin
    if (ctrl.wr && ctrl.wr_sel == 6'(IDX)) begin
      cent_mem[AW'(ctrl.addr)] <= ctrl.value;
    end
    if (ctrl.rd) begin
      cent_q_r <= cent_mem[AW'(ctrl.addr)];
    end
  end

  assign diff   = (ctrl.value >= cent_q_r) ? ctrl.value - cent_q_r : cent_q_r - ctrl.value;
  assign active = 7'(IDX) < ctrl.keff;
  assign need   = {1'b0, load_r} + {21'b0, ctrl.nnz};
  assign elig   = need <= {1'b0, ctrl.max_cap};
  assign key    = (load_r < ctrl.min_cap) ? {2'b00, acc_r} : {acc_r, 2'b00};

  always_comb begin
    cand_nxt = cand_in;
    if (cand_in.valid && active) begin
      if (elig && (!cand_in.found || key < cand_in.key)) begin
        cand_nxt.found = 1'b1;
        cand_nxt.key   = key;
        cand_nxt.idx   = 6'(IDX);
      end
      if (IDX == 0 || load_r < cand_in.ml_load) begin
        cand_nxt.ml_load = load_r;
        cand_nxt.ml_idx  = 6'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sq) begin
      sq_r <= 32'(diff) * 32'(diff);
    end
    if (!rst_n) begin
      acc_r        <= '0;
      load_r       <= '0;
      cand_r.valid <= 1'b0;
    end else begin
      if (ctrl.clr_acc) begin
        acc_r <= '0;
      end else if (ctrl.acc) begin
        acc_r <= cbnc_pkg::sat_add40(acc_r, {8'b0, sq_r});
      end
      if (ctrl.clr_load) begin
        load_r <= '0;
      end else if (ctrl.upd && ctrl.win == 6'(IDX)) begin
        load_r <= cbnc_pkg::sat_add40(load_r, {20'b0, ctrl.nnz});
      end
      cand_r <= cand_nxt;
    end
  end

  assign cand_out = cand_r;

endmodule

/* design/capacity_bounded_nearest_centroid.sv */
// channel | dir | signals                           | contents
// in_     | in  | tvalid tready tdata[63:0] tuser tlast | commands and feature elements
// out_    | out | tvalid tready tdata[23:0]         | column assignments
// cfg_    | in  | we index[1:0] wdata[39:0]          | register writes
// centroid load, pass start, ignored command: accepted in S_IDLE, applied in S_CMD
// feature element: centroid read, square, accumulate in every cell (S_RD, S_SQ, S_ACC)
// last element: the selection is injected (S_INJ), walks the registered cell chain, is taken in S_WAIT
// after reset a clearing pass writes UNASSIGNED to every entry of the prior-assignment memory
// a waiting result holds in the output register; the input stalls only if a new result must wait
module capacity_bounded_nearest_centroid #(
  parameter int MAX_CLUSTERS = cbnc_pkg::MAX_CLUSTERS_DEF,
  parameter int FEATURE_DIM  = cbnc_pkg::FEATURE_DIM_DEF,
  parameter int MAX_COLUMNS  = cbnc_pkg::MAX_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cluster_sel, dim_index, feature_value, column_index, column_nnz
  input  logic [63:0] in_tdata,
  // command
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_column, out_cluster, changed, overflow_fallback
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_COLUMNS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CMD, S_RD, S_SQ, S_ACC, S_INJ, S_WAIT
  } state_t;

  state_t state_r;
  logic   fin_r;

  logic [1:0]  cmd_r;
  logic [5:0]  csel_r;
  logic [4:0]  dim_r;
  logic [15:0] val_r;
  logic [15:0] col_r;
  logic [19:0] nnz_r;
  logic        last_r;

  logic [6:0]  ncl_r;
  logic [39:0] min_cap_r;
  logic [39:0] max_cap_r;
  logic [6:0]  keff;

  logic [CW-1:0] clr_cnt_r;
  logic [6:0]    pri_mem [MAX_COLUMNS];
  logic [6:0]    pri_q_r;
  logic [CW-1:0] col_addr;
  logic          col_ok;
  logic          dim_ok;

  logic [5:0] win_r;
  logic       fb_r;
  logic       out_valid_r;
  logic [23:0] out_data_r;
  logic       fin_go;
  logic [6:0] prior;

  cbnc_pkg::ctrl_t ctrl;
  cbnc_pkg::cand_t chain [MAX_CLUSTERS+1];

  assign keff = (ncl_r == 7'd0) ? 7'd1 :
                (ncl_r > 7'(MAX_CLUSTERS)) ? 7'(MAX_CLUSTERS) : ncl_r;
  assign col_addr = CW'(col_r);
  assign col_ok   = 32'(col_r) < 32'(MAX_COLUMNS);
  assign dim_ok   = 32'(dim_r) < 32'(FEATURE_DIM);
  assign fin_go   = fin_r && (!out_valid_r || out_tready);
  assign prior    = col_ok ? pri_q_r : cbnc_pkg::UNASSIGNED;
  assign in_tready = (state_r == S_IDLE) && !fin_r;

  always_comb begin
    ctrl          = '0;
    ctrl.wr       = (state_r == S_CMD) && (cmd_r == cbnc_pkg::CMD_LOAD) && dim_ok;
    ctrl.wr_sel   = csel_r;
    ctrl.addr     = {1'b0, dim_r};
    ctrl.value    = val_r;
    ctrl.rd       = state_r == S_RD;
    ctrl.sq       = state_r == S_SQ;
    ctrl.acc      = state_r == S_ACC;
    ctrl.clr_load = (state_r == S_CMD) && (cmd_r == cbnc_pkg::CMD_START);
    ctrl.clr_acc  = ctrl.clr_load || fin_go;
    ctrl.upd      = fin_go;
    ctrl.win      = win_r;
    ctrl.nnz      = nnz_r;
    ctrl.min_cap  = min_cap_r;
    ctrl.max_cap  = max_cap_r;
    ctrl.keff     = keff;
  end

  assign chain[0] = '{valid: (state_r == S_INJ), default: '0};

  for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
    cbnc_cell #(.IDX(i), .FEATURE_DIM(FEATURE_DIM)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      pri_mem[clr_cnt_r] <= cbnc_pkg::UNASSIGNED;
    end else if (fin_go && col_ok) begin
      pri_mem[col_addr] <= {1'b0, win_r};
    end
    if (state_r == S_INJ) begin
      pri_q_r <= pri_mem[col_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      csel_r <= in_tdata[5:0];
      dim_r  <= in_tdata[10:6];
      val_r  <= in_tdata[26:11];
      col_r  <= in_tdata[42:27];
      nnz_r  <= in_tdata[62:43];
      last_r <= in_tlast;
    end
    if (state_r == S_WAIT && chain[MAX_CLUSTERS].valid) begin
      win_r <= chain[MAX_CLUSTERS].found ? chain[MAX_CLUSTERS].idx
                                         : chain[MAX_CLUSTERS].ml_idx;
      fb_r  <= !chain[MAX_CLUSTERS].found;
    end
    if (fin_go) begin
      out_data_r <= {fb_r, prior != {1'b0, win_r}, win_r, col_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      ncl_r       <= 7'd64;
      min_cap_r   <= '0;
      max_cap_r   <= cbnc_pkg::SAT40;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cbnc_pkg::REG_NUM_CLUSTERS: ncl_r     <= cfg_wdata[6:0];
          cbnc_pkg::REG_MIN_CAP:      min_cap_r <= cfg_wdata;
          cbnc_pkg::REG_MAX_CAP:      max_cap_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
        fin_r       <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CW'(MAX_COLUMNS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            if (in_tuser == cbnc_pkg::CMD_COLUMN) begin
              if (32'(in_tdata[10:6]) < 32'(FEATURE_DIM)) begin
                state_r <= S_RD;
              end else if (in_tlast) begin
                state_r <= S_INJ;
              end else begin
                state_r <= S_CMD;
              end
            end else begin
              state_r <= S_CMD;
            end
          end
        end
        S_CMD: state_r <= S_IDLE;
        S_RD:  state_r <= S_SQ;
        S_SQ:  state_r <= S_ACC;
        S_ACC: state_r <= last_r ? S_INJ : S_IDLE;
        S_INJ: state_r <= S_WAIT;
        S_WAIT: begin
          if (chain[MAX_CLUSTERS].valid) begin
            fin_r   <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/cbnc_checker.sv */
module cbnc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

endmodule

bind capacity_bounded_nearest_centroid cbnc_checker u_cbnc_checker (.*);
